@@ rtl/acir_pkg.sv @@
package acir_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned NumRegs   = 6;
  localparam int unsigned FrameBits = 64;
  localparam int unsigned SegWidth  = 8;

  localparam logic [FrameBits-1:0] BaseWord = 64'h1090_0000_2C2A_5584;
  localparam logic [7:0] TempMin = 8'd16;
  localparam logic [7:0] TempMax = 8'd30;

  localparam logic [SegWidth-1:0] SegHdrMark  = 8'd0;
  localparam logic [SegWidth-1:0] SegHdrSpace = 8'd1;
  localparam logic [SegWidth-1:0] SegFirstBit = 8'd3;
  localparam logic [SegWidth-1:0] SegLast     = 8'd131;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_HDR_MARK    = 3'd0,
    REG_HDR_SPACE   = 3'd1,
    REG_BIT_MARK    = 3'd2,
    REG_ONE_SPACE   = 3'd3,
    REG_ZERO_SPACE  = 3'd4,
    REG_TRAILER_GAP = 3'd5
  } cfg_reg_t;

  localparam logic [2:0] ModeHeat = 3'd0;
  localparam logic [2:0] ModeFan  = 3'd2;
  localparam logic [1:0] BitsHeat = 2'd1;
  localparam logic [1:0] BitsCool = 2'd2;
  localparam logic [1:0] BitsFan  = 2'd3;

  typedef logic [CfgWidth-1:0] cfg_word_t;
  typedef cfg_word_t [NumRegs-1:0] cfg_bank_t;

  typedef struct packed {
    logic                 start;
    logic [7:0]           set_temperature;
    logic [2:0]           ac_mode_code;
    logic [1:0]           fan_level;
    logic                 vertical_swing;
    logic                 power_enable;
  } item_t;

  typedef struct packed {
    logic                 led_on;
    logic                 busy_res;
    logic                 frame_end;
    logic [FrameBits-1:0] frame_word;
  } result_t;

endpackage

@@ rtl/acir_if.sv @@
interface acir_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] set_temperature;
  logic [2:0] ac_mode_code;
  logic [1:0] fan_level;
  logic       vertical_swing;
  logic       power_enable;

  modport source (
    output valid, opcode, set_temperature, ac_mode_code, fan_level,
           vertical_swing, power_enable,
    input  ready
  );
  modport sink (
    input  valid, opcode, set_temperature, ac_mode_code, fan_level,
           vertical_swing, power_enable,
    output ready
  );
endinterface

interface acir_out_if;
  logic        valid;
  logic        ready;
  logic        led_on;
  logic        busy_res;
  logic        frame_end;
  logic [63:0] frame_word;

  modport source (
    output valid, led_on, busy_res, frame_end, frame_word,
    input  ready
  );
  modport sink (
    input  valid, led_on, busy_res, frame_end, frame_word,
    output ready
  );
endinterface

@@ rtl/ac_ir_frame_transmitter.sv @@
// IR frame transmitter for a 64-bit air-conditioner remote frame.
// in_ch carries items: opcode start builds the frame from temperature, mode,
// fan, swing and power (ignored while a frame is in progress); opcode tick is
// one microsecond of envelope time. Every item gives exactly one result on
// out_ch: led_on for a mark tick, busy_res, frame_end on the last gap tick,
// and the stored frame word.
// The envelope is 132 segments: header mark and space, a mark plus a one or
// zero space per bit (LSB first), a trailing mark and the trailer gap. Segment
// lengths come from six 16-bit registers on the cfg_we/cfg_index/cfg_wdata
// port; write them only while idle. Writes to indexes above 5 are dropped.
// The result register loads at the edge that accepts the item. Throughput is
// one item per cycle while the receiver takes each result, set by the single
// result register; in_ch.ready is high whenever that register is empty or
// being taken in the same cycle, so a stalled receiver holds back one result
// and then stops the input side.
// Reset (rst, synchronous) restores the default lengths, clears the frame,
// goes idle and empties the result register.
module ac_ir_frame_transmitter (
  input  logic                       clk,
  input  logic                       rst,
  acir_in_if.sink                    in_ch,
  acir_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [acir_pkg::CfgWidth-1:0] cfg_wdata
);
  import acir_pkg::*;

  cfg_bank_t            cfg;
  item_t                item;
  logic [FrameBits-1:0] frame_new;
  result_t              res;
  logic                 sending;
  logic                 accept;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    item.start           = (in_ch.opcode == OP_START);
    item.set_temperature = in_ch.set_temperature;
    item.ac_mode_code    = in_ch.ac_mode_code;
    item.fan_level       = in_ch.fan_level;
    item.vertical_swing  = in_ch.vertical_swing;
    item.power_enable    = in_ch.power_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_HDR_MARK]    <= 16'd8940;
      cfg[REG_HDR_SPACE]   <= 16'd4556;
      cfg[REG_BIT_MARK]    <= 16'd503;
      cfg[REG_ONE_SPACE]   <= 16'd1736;
      cfg[REG_ZERO_SPACE]  <= 16'd615;
      cfg[REG_TRAILER_GAP] <= 16'd30000;
    end else if (cfg_we && (cfg_index <= REG_TRAILER_GAP)) begin
      cfg[cfg_index] <= cfg_wdata;
    end
  end

  acir_framer u_framer (
    .item  (item),
    .frame (frame_new)
  );

  acir_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .item      (item),
    .frame_new (frame_new),
    .cfg       (cfg),
    .res       (res),
    .sending   (sending)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.led_on     <= res.led_on;
      out_ch.busy_res   <= res.busy_res;
      out_ch.frame_end  <= res.frame_end;
      out_ch.frame_word <= res.frame_word;
    end
  end

  a_end_is_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_end |-> !out_ch.busy_res)
    else $error("frame_end reported while still busy");

  a_start_taken: assert property (@(posedge clk) disable iff (rst)
    accept && item.start && !sending |=>
      out_ch.busy_res && !out_ch.frame_end && !out_ch.led_on)
    else $error("start from idle did not begin a frame");

  a_idle_tick_dark: assert property (@(posedge clk) disable iff (rst)
    accept && !item.start && !sending |=> !out_ch.led_on && !out_ch.busy_res)
    else $error("tick while idle lit the LED or went busy");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    accept && sending |=> out_ch.frame_word == $past(res.frame_word))
    else $error("result frame word differs from the held frame");

endmodule

@@ rtl/acir_framer.sv @@
module acir_framer (
  input  acir_pkg::item_t                   item,
  output logic [acir_pkg::FrameBits-1:0]    frame
);
  import acir_pkg::*;

  logic [7:0]           temp_clamped;
  logic [7:0]           temp_off;
  logic [1:0]           mode_bits;
  logic [FrameBits-1:0] w;
  logic [3:0]           sum_lo;
  logic [3:0]           sum_hi;

  always_comb begin
    if (item.set_temperature < TempMin) begin
      temp_clamped = TempMin;
    end else if (item.set_temperature > TempMax) begin
      temp_clamped = TempMax;
    end else begin
      temp_clamped = item.set_temperature;
    end
    temp_off = temp_clamped - TempMin;

    if (item.ac_mode_code == ModeHeat) begin
      mode_bits = BitsHeat;
    end else if (item.ac_mode_code == ModeFan) begin
      mode_bits = BitsFan;
    end else begin
      mode_bits = BitsCool;
    end

    w          = BaseWord;
    w[31:16]   = '0;
    w[21:20]   = mode_bits;
    w[23:22]   = item.fan_level;
    w[27:24]   = temp_off[3:0];
    w[29]      = item.vertical_swing;
    w[36]      = item.power_enable;

    // checksum over the eleven nibbles at bits 20..63, as partial sums of six and five nibbles
    sum_lo = '0;
    for (int k = 0; k < 6; k++) begin
      sum_lo = sum_lo + w[20 + 4*k +: 4];
    end
    sum_hi = '0;
    for (int k = 6; k < 11; k++) begin
      sum_hi = sum_hi + w[20 + 4*k +: 4];
    end
    w[19:16] = sum_lo + sum_hi;

    frame = w;
  end

endmodule

@@ rtl/acir_seq.sv @@
module acir_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  acir_pkg::item_t                   item,
  input  logic [acir_pkg::FrameBits-1:0]    frame_new,
  input  acir_pkg::cfg_bank_t               cfg,
  output acir_pkg::result_t                 res,
  output logic                              sending
);
  import acir_pkg::*;

  logic [FrameBits-1:0] frame_reg;
  logic [FrameBits-1:0] frame_reg_next;
  logic [SegWidth-1:0]  segment_index;
  logic [SegWidth-1:0]  segment_index_next;
  logic [CfgWidth-1:0]  ticks_left;
  logic [CfgWidth-1:0]  ticks_left_next;
  logic                 sending_next;
  logic                 led;
  logic                 fend;
  logic [SegWidth-1:0]  seg_inc;
  logic [SegWidth-1:0]  bit_off;
  logic [CfgWidth-1:0]  seg_len;

  // length of the segment that follows the current one
  always_comb begin
    seg_inc = segment_index + 1'b1;
    bit_off = seg_inc - SegFirstBit;
    if (seg_inc == SegHdrSpace) begin
      seg_len = cfg[REG_HDR_SPACE];
    end else if (seg_inc == SegLast) begin
      seg_len = cfg[REG_TRAILER_GAP];
    end else if (!seg_inc[0]) begin
      seg_len = cfg[REG_BIT_MARK];
    end else if (frame_reg[bit_off[6:1]]) begin
      seg_len = cfg[REG_ONE_SPACE];
    end else begin
      seg_len = cfg[REG_ZERO_SPACE];
    end
  end

  always_comb begin
    frame_reg_next     = frame_reg;
    segment_index_next = segment_index;
    ticks_left_next    = ticks_left;
    sending_next       = sending;
    led                = 1'b0;
    fend               = 1'b0;
    if (item.start) begin
      if (!sending) begin
        frame_reg_next     = frame_new;
        segment_index_next = SegHdrMark;
        ticks_left_next    = cfg[REG_HDR_MARK];
        sending_next       = 1'b1;
      end
    end else if (sending) begin
      led = ~segment_index[0];
      // a length of zero counts as one tick
      if (ticks_left <= 16'd1) begin
        if (segment_index == SegLast) begin
          sending_next       = 1'b0;
          segment_index_next = SegHdrMark;
          ticks_left_next    = '0;
          fend               = 1'b1;
        end else begin
          segment_index_next = seg_inc;
          ticks_left_next    = seg_len;
        end
      end else begin
        ticks_left_next = ticks_left - 1'b1;
      end
    end
  end

  always_comb begin
    res.led_on     = led;
    res.busy_res   = sending_next;
    res.frame_end  = fend;
    res.frame_word = frame_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_reg     <= '0;
      segment_index <= '0;
      ticks_left    <= '0;
      sending       <= 1'b0;
    end else if (en) begin
      frame_reg     <= frame_reg_next;
      segment_index <= segment_index_next;
      ticks_left    <= ticks_left_next;
      sending       <= sending_next;
    end
  end

endmodule
